>>> hw/rtl/b58d_pkg.sv
// Shared types, status codes and lookup functions for the Base58 block decoder.
package b58d_pkg;

   localparam int unsigned FULL_CHARS = 11;
   localparam int unsigned FULL_BYTES = 8;
   localparam int unsigned RADIX      = 58;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_CHAR = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_NONCANON = 3'd3,
      ST_BAD_LEN  = 3'd4
   } status_type;

   // One closed block: value plus byte count, or an error with a count of one.
   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  nbytes;
      status_type  status;
      logic        done;
   } blk_rec_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] digit;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.digit = 6'd0;
      if (c >= "1" && c <= "9") begin
         d.digit = 6'(c - 8'd49);
      end else if (c >= "A" && c <= "H") begin
         d.digit = 6'(c - 8'd65 + 8'd9);
      end else if (c >= "J" && c <= "N") begin
         d.digit = 6'(c - 8'd74 + 8'd17);
      end else if (c >= "P" && c <= "Z") begin
         d.digit = 6'(c - 8'd80 + 8'd22);
      end else if (c >= "a" && c <= "k") begin
         d.digit = 6'(c - 8'd97 + 8'd33);
      end else if (c >= "m" && c <= "z") begin
         d.digit = 6'(c - 8'd109 + 8'd44);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   // Decoded byte count of a final block; zero means the length is invalid.
   function automatic logic [3:0] tail_bytes(input logic [3:0] n);
      logic [3:0] b;
      unique case (n)
         4'd2:    b = 4'd1;
         4'd3:    b = 4'd2;
         4'd5:    b = 4'd3;
         4'd6:    b = 4'd4;
         4'd7:    b = 4'd5;
         4'd9:    b = 4'd6;
         4'd10:   b = 4'd7;
         4'd11:   b = 4'd8;
         default: b = 4'd0;
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/base58_block_decoder_unit.sv
// Top level of the Base58 block decoder: character accumulator and byte serializer.
// Takes one Base58 character per request and returns decoded bytes, most significant
// byte of each block first. A character is accepted every cycle unless a closed block
// waits in the holding buffer while the byte output register is still streaming the
// block before it; a full block of 11 characters then streams 8 bytes, one per cycle
// while rsp_ready is high, as the next block accumulates, so the sustained rate is one
// character per cycle. A partial final block gives 1 to 7 bytes; any error gives a single
// result with a zero byte and a nonzero status, and the rest of that string is dropped
// without results. A result passes the holding buffer, then the output register.
module base58_block_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);
   import b58d_pkg::*;

   logic        accept;
   logic        rec_valid;
   blk_rec_type rec;
   logic        pend_full;

   // hold off new characters while a closed block waits for the output side
   assign req_ready = !pend_full;
   assign accept    = req_valid && req_ready;

   b58d_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .symbol        (req_symbol),
      .end_of_string (req_end_of_string),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   b58d_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (rec_valid),
      .load_rec        (rec),
      .pend_full       (pend_full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_status      (rsp_status),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

endmodule

>>> hw/rtl/b58d_accum.sv
// Per-character accumulator: folds digits into the block value and closes blocks.
module b58d_accum (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         symbol,
   input  logic               end_of_string,
   output logic               rec_valid,
   output b58d_pkg::blk_rec_type rec
);
   import b58d_pkg::*;

   logic [63:0] value_ff, value_in;
   logic [3:0]  count_ff, count_in;
   logic        bad_ff, bad_in;
   logic        ovf_ff, ovf_in;
   logic        discard_ff, discard_in;

   digit_type   dig;
   logic [70:0] sum;
   logic [63:0] new_value;
   logic [3:0]  new_count;
   logic        new_bad;
   logic        new_ovf;
   logic        closing;
   logic [3:0]  nbytes;
   logic [7:0]  byte_nz;
   logic [7:0]  keep_mask;
   logic        noncanon;
   status_type  status;

   always_comb begin
      dig       = digit_of(symbol);
      // value * 58 = value * 64 - value * 4 - value * 2
      sum       = ({1'b0, value_ff, 6'd0} - {5'd0, value_ff, 2'd0}
                   - {6'd0, value_ff, 1'b0}) + 71'(dig.digit);
      new_value = sum[63:0];
      new_ovf   = ovf_ff | (|sum[70:64]);
      new_bad   = bad_ff | ~dig.valid;
      new_count = count_ff + 4'd1;
      closing   = (new_count == 4'(FULL_CHARS)) || end_of_string;
      nbytes    = tail_bytes(new_count);

      for (int k = 0; k < 8; k++) begin
         byte_nz[k] = |new_value[8*k +: 8];
      end
      keep_mask = 8'hFF << nbytes;
      noncanon  = |(byte_nz & keep_mask);

      if (nbytes == 4'd0) begin
         status = ST_BAD_LEN;
      end else if (new_bad) begin
         status = ST_BAD_CHAR;
      end else if (new_ovf) begin
         status = ST_OVERFLOW;
      end else if (noncanon) begin
         status = ST_NONCANON;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      value_in   = value_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      ovf_in     = ovf_ff;
      discard_in = discard_ff;
      rec_valid  = 1'b0;
      rec.value  = new_value;
      rec.nbytes = nbytes;
      rec.status = status;
      rec.done   = end_of_string;

      if (accept) begin
         if (discard_ff) begin
            // drop until the string's last character
            if (end_of_string) begin
               discard_in = 1'b0;
            end
         end else if (!closing) begin
            value_in = new_value;
            count_in = new_count;
            bad_in   = new_bad;
            ovf_in   = new_ovf;
         end else begin
            rec_valid = 1'b1;
            value_in  = '0;
            count_in  = '0;
            bad_in    = 1'b0;
            ovf_in    = 1'b0;
            if (status != ST_OK) begin
               rec.value  = '0;
               rec.nbytes = 4'd1;
               rec.done   = 1'b1;
               discard_in = ~end_of_string;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= '0;
         count_ff   <= '0;
         bad_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         discard_ff <= 1'b0;
      end else begin
         value_ff   <= value_in;
         count_ff   <= count_in;
         bad_ff     <= bad_in;
         ovf_ff     <= ovf_in;
         discard_ff <= discard_in;
      end
   end

endmodule

>>> hw/rtl/b58d_serializer.sv
// Two-entry block buffer that streams each closed block out byte by byte.
module b58d_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   input  b58d_pkg::blk_rec_type load_rec,
   output logic               pend_full,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_data_byte,
   output logic [2:0]         rsp_status,
   output logic               rsp_run_last,
   output logic               rsp_string_done
);
   import b58d_pkg::*;

   logic        pend_valid_ff, pend_valid_in;
   blk_rec_type pend_ff, pend_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [63:0] cur_value_ff, cur_value_in;
   logic [3:0]  cur_left_ff, cur_left_in;
   status_type  cur_status_ff, cur_status_in;
   logic        cur_done_ff, cur_done_in;

   logic        take;
   logic        last_byte;
   logic        move;
   logic [2:0]  sel;

   assign take      = cur_valid_ff && rsp_ready;
   assign last_byte = (cur_left_ff == 4'd1);
   assign move      = pend_valid_ff && (!cur_valid_ff || (take && last_byte));
   assign sel       = 3'(cur_left_ff - 4'd1);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      cur_valid_in  = cur_valid_ff;
      cur_value_in  = cur_value_ff;
      cur_left_in   = cur_left_ff;
      cur_status_in = cur_status_ff;
      cur_done_in   = cur_done_ff;

      if (load_valid) begin
         pend_valid_in = 1'b1;
         pend_in       = load_rec;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end

      if (move) begin
         cur_valid_in  = 1'b1;
         cur_value_in  = pend_ff.value;
         cur_left_in   = pend_ff.nbytes;
         cur_status_in = pend_ff.status;
         cur_done_in   = pend_ff.done;
      end else if (take) begin
         if (last_byte) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_left_in = cur_left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_valid_ff  <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      cur_value_ff  <= cur_value_in;
      cur_left_ff   <= cur_left_in;
      cur_status_ff <= cur_status_in;
      cur_done_ff   <= cur_done_in;
   end

   // an idle output register takes the pending block this cycle, so a new one may load
   assign pend_full       = pend_valid_ff && cur_valid_ff;
   assign rsp_valid       = cur_valid_ff;
   assign rsp_data_byte   = cur_value_ff[{sel, 3'b000} +: 8];
   assign rsp_status      = cur_status_ff;
   assign rsp_run_last    = last_byte;
   assign rsp_string_done = cur_done_ff;

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_left_ff != 4'd0) && (cur_left_ff <= 4'(FULL_BYTES)))
      else $error("byte count out of range on active block");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_valid |-> !(pend_valid_ff && cur_valid_ff))
      else $error("block loaded over a pending block");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && cur_status_ff != ST_OK) |-> last_byte && cur_done_ff
         && (rsp_data_byte == 8'd0))
      else $error("error result is not a single zero byte ending the string");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && !rsp_ready) |=> cur_valid_ff && $stable(cur_left_ff))
      else $error("active block advanced without a handshake");

endmodule
